@@ rtl/assert_macros.svh @@
// Shared assertion helpers, clocked on clk with reset masking.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define ASSERT_CLKD(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_CLKD(label, !(cond), msg)

`endif

@@ rtl/pdm_pkg.sv @@
`timescale 1ns / 1ps

package pdm_pkg;

    localparam int MAX_STATES_DEF = 32;
    localparam int MAX_DIMS_DEF   = 16;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int IDX_W      = 5;
    localparam int DIST_W     = 36;

    // |a-b| needs one bit more than a coordinate; its square twice that
    localparam int MAG_W  = COORD_BITS + 1;
    localparam int TERM_W = 2 * MAG_W;
    localparam int SUM_W  = ((TERM_W > DIST_W) ? TERM_W : DIST_W) + 1;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam int METRIC_W   = 2;
    localparam int NSTATES_W  = 6;
    localparam int NDIMS_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [METRIC_W-1:0] METRIC_ABS  = 2'd0;
    localparam logic [METRIC_W-1:0] METRIC_SQR  = 2'd1;
    localparam logic [METRIC_W-1:0] METRIC_HAM  = 2'd2;
    // unassigned code, behaves as absolute difference
    localparam logic [METRIC_W-1:0] METRIC_RSVD = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_METRIC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STATES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMS   = 2'd2;

    localparam logic [NSTATES_W-1:0] NUM_STATES_RST = 6'd32;
    localparam logic [NDIMS_W-1:0]   NUM_DIMS_RST   = 5'd16;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] coordinate;
        logic                         start_matrix;
    } item_beat_t;

    typedef struct packed {
        logic [IDX_W-1:0]  row_index;
        logic [IDX_W-1:0]  col_index;
        logic [DIST_W-1:0] distance;
        logic              last_of_row;
    } result_beat_t;

endpackage

@@ rtl/pairwise_distance_matrix_core.sv @@
// Streams a location matrix in row-major order, one signed Q8.8 coordinate per
// beat, and emits the lower triangle of its pairwise distance matrix (L1,
// squared difference or integer-part Hamming, selected by the metric register).
// Each coordinate is run against the same coordinate of every earlier row
// through one shared difference/multiply/accumulate pipe, one earlier row per
// cycle: a coordinate of row r holds the input stalled through its r issues,
// the term and accumulate stages and a final drain check.
// On the last coordinate of a row the block then emits r result beats, one per
// cycle while the result side does not stall; the input takes the next
// coordinate as soon as the last of those beats is in the output register.
// Row 0 never stalls the input.
`timescale 1ns / 1ps

module pairwise_distance_matrix_core
    import pdm_pkg::*;
#(
    parameter int MAX_STATES = MAX_STATES_DEF,
    parameter int MAX_DIMS   = MAX_DIMS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  item_valid,
    output logic                  item_stall,
    input  item_beat_t            item,

    output logic                  result_valid,
    input  logic                  result_stall,
    output result_beat_t          result,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ROW_W     = $clog2(MAX_STATES);
    localparam int ROWCNT_W  = $clog2(MAX_STATES + 1);
    localparam int DIM_W     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int DIMCNT_W  = $clog2(MAX_DIMS + 1);
    localparam int MEM_DEPTH = MAX_STATES * MAX_DIMS;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ACCUM = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    // configuration
    logic [METRIC_W-1:0]  metric_reg;
    logic [NSTATES_W-1:0] num_states_reg;
    logic [NDIMS_W-1:0]   num_dims_reg;

    // sequencer and position
    logic [1:0]           state_reg;
    logic [ROW_W-1:0]     row_pos_reg;
    logic [DIM_W-1:0]     dim_pos_reg;
    logic [ADDR_W-1:0]    row_base_reg;
    logic [ROW_W-1:0]     cur_row_reg;
    logic                 cur_last_reg;
    logic [COORD_BITS-1:0] coord_reg;
    logic [ROW_W-1:0]     jp_iss_reg;
    logic [ADDR_W-1:0]    rd_addr_reg;
    logic [ROW_W-1:0]     emit_idx_reg;

    // accumulate pipe
    logic                 s1_vld_reg;
    logic [ROW_W-1:0]     s1_idx_reg;
    logic [COORD_BITS-1:0] rd_data_reg;
    logic                 s2_vld_reg;
    logic [ROW_W-1:0]     s2_idx_reg;
    logic [TERM_W-1:0]    term_reg;
    logic [TERM_W-1:0]    term_next;

    logic [COORD_BITS-1:0] mem [MEM_DEPTH];
    logic [DIST_W-1:0]    psum_reg [MAX_STATES];
    logic [MAX_STATES-1:0] psum_vld_reg;

    logic                 result_valid_reg;
    result_beat_t         result_reg;

    logic                 accept;
    logic [ROW_W-1:0]     eff_row;
    logic [DIM_W-1:0]     eff_dim;
    logic [ADDR_W-1:0]    eff_base;
    logic [ROWCNT_W-1:0]  ns_eff;
    logic [DIMCNT_W-1:0]  nd_eff;
    logic                 dim_last;
    logic                 row_last;
    logic [ADDR_W-1:0]    wr_addr;
    logic                 issue;
    logic                 accum_done;
    logic                 load_out;
    logic                 emit_last;
    logic [ROW_W-1:0]     psum_raddr;
    logic [DIST_W-1:0]    psum_cur;
    logic [SUM_W-1:0]     sum_wide;
    logic [DIST_W-1:0]    sum_sat;

    logic signed [COORD_BITS-1:0] op_a;
    logic signed [COORD_BITS-1:0] op_b;
    logic signed [MAG_W-1:0]      diff;
    logic [MAG_W-1:0]             mag;
    logic [TERM_W-1:0]            sq;

    // integer part, truncated toward zero
    function automatic logic signed [COORD_BITS-1:0] int_part(
        input logic signed [COORD_BITS-1:0] v
    );
        logic signed [COORD_BITS-1:0] q;
        begin
            q = v >>> FRAC_BITS;
            if (v[COORD_BITS-1] && (v[FRAC_BITS-1:0] != '0))
            begin
                q = q + COORD_BITS'(1);
            end
            return q;
        end
    endfunction

    assign cfg_ready    = 1'b1;
    assign item_stall   = (state_reg != ST_IDLE);
    assign accept       = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        if (num_states_reg == '0)
            ns_eff = ROWCNT_W'(1);
        else if (32'(num_states_reg) > 32'(MAX_STATES))
            ns_eff = ROWCNT_W'(MAX_STATES);
        else
            ns_eff = ROWCNT_W'(num_states_reg);

        if (num_dims_reg == '0)
            nd_eff = DIMCNT_W'(1);
        else if (32'(num_dims_reg) > 32'(MAX_DIMS))
            nd_eff = DIMCNT_W'(MAX_DIMS);
        else
            nd_eff = DIMCNT_W'(num_dims_reg);
    end

    // start_matrix restarts at row 0, dimension 0
    assign eff_row  = item.start_matrix ? '0 : row_pos_reg;
    assign eff_dim  = item.start_matrix ? '0 : dim_pos_reg;
    assign eff_base = item.start_matrix ? '0 : row_base_reg;
    assign wr_addr  = eff_base + ADDR_W'(eff_dim);
    assign dim_last = (DIMCNT_W'(eff_dim) + DIMCNT_W'(1)) >= nd_eff;
    assign row_last = (ROWCNT_W'(eff_row) + ROWCNT_W'(1)) >= ns_eff;

    assign issue      = (state_reg == ST_ACCUM) && (jp_iss_reg != cur_row_reg);
    assign accum_done = (state_reg == ST_ACCUM) && (jp_iss_reg == cur_row_reg)
                        && !s1_vld_reg && !s2_vld_reg;
    assign load_out   = (state_reg == ST_EMIT) && (!result_valid_reg || !result_stall);
    assign emit_last  = (ROW_W'(emit_idx_reg + ROW_W'(1)) == cur_row_reg);

    // difference, square and hamming term
    always_comb
    begin
        op_a = $signed(coord_reg);
        op_b = $signed(rd_data_reg);
        diff = MAG_W'(op_a) - MAG_W'(op_b);
        mag  = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
        sq   = TERM_W'(mag) * TERM_W'(mag);
        case (metric_reg)
            METRIC_SQR: term_next = sq;
            METRIC_HAM: term_next = TERM_W'(int_part(op_a) != int_part(op_b));
            default:    term_next = TERM_W'(mag);
        endcase
    end

    // saturating accumulate
    assign psum_raddr = s2_vld_reg ? s2_idx_reg : emit_idx_reg;
    assign psum_cur   = psum_vld_reg[psum_raddr] ? psum_reg[psum_raddr] : '0;
    assign sum_wide   = SUM_W'(psum_cur) + SUM_W'(term_reg);
    assign sum_sat    = (sum_wide >= SUM_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(sum_wide);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metric_reg     <= METRIC_ABS;
            num_states_reg <= NUM_STATES_RST;
            num_dims_reg   <= NUM_DIMS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_METRIC: metric_reg     <= METRIC_W'(cfg_data);
                CFG_STATES: num_states_reg <= NSTATES_W'(cfg_data);
                CFG_DIMS:   num_dims_reg   <= NDIMS_W'(cfg_data);
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            row_pos_reg      <= '0;
            dim_pos_reg      <= '0;
            row_base_reg     <= '0;
            cur_row_reg      <= '0;
            cur_last_reg     <= 1'b0;
            jp_iss_reg       <= '0;
            emit_idx_reg     <= '0;
            s1_vld_reg       <= 1'b0;
            s2_vld_reg       <= 1'b0;
            psum_vld_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= issue;
            s2_vld_reg <= s1_vld_reg;

            if (load_out)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        cur_row_reg  <= eff_row;
                        cur_last_reg <= dim_last;
                        jp_iss_reg   <= '0;
                        emit_idx_reg <= '0;
                        if (item.start_matrix)
                            psum_vld_reg <= '0;
                        if (dim_last)
                        begin
                            dim_pos_reg <= '0;
                            if (row_last)
                            begin
                                row_pos_reg  <= '0;
                                row_base_reg <= '0;
                            end
                            else
                            begin
                                row_pos_reg  <= eff_row + ROW_W'(1);
                                row_base_reg <= eff_base + ADDR_W'(MAX_DIMS);
                            end
                        end
                        else
                        begin
                            dim_pos_reg  <= eff_dim + DIM_W'(1);
                            row_pos_reg  <= eff_row;
                            row_base_reg <= eff_base;
                        end
                        // row 0 has nothing to compare against
                        if (eff_row != '0)
                            state_reg <= ST_ACCUM;
                    end
                end
                ST_ACCUM:
                begin
                    if (issue)
                        jp_iss_reg <= jp_iss_reg + ROW_W'(1);
                    if (s2_vld_reg)
                        psum_vld_reg[s2_idx_reg] <= 1'b1;
                    if (accum_done)
                        state_reg <= cur_last_reg ? ST_EMIT : ST_IDLE;
                end
                ST_EMIT:
                begin
                    if (load_out)
                    begin
                        psum_vld_reg[emit_idx_reg] <= 1'b0;
                        emit_idx_reg <= emit_idx_reg + ROW_W'(1);
                        if (emit_last)
                            state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            coord_reg   <= item.coordinate;
            rd_addr_reg <= ADDR_W'(eff_dim);
        end
        else if (issue)
        begin
            rd_addr_reg <= rd_addr_reg + ADDR_W'(MAX_DIMS);
        end
        s1_idx_reg <= jp_iss_reg;
        s2_idx_reg <= s1_idx_reg;
        term_reg   <= term_next;
        if (s2_vld_reg)
            psum_reg[s2_idx_reg] <= sum_sat;
        if (load_out)
        begin
            result_reg.row_index   <= IDX_W'(cur_row_reg);
            result_reg.col_index   <= IDX_W'(emit_idx_reg);
            result_reg.distance    <= psum_cur;
            result_reg.last_of_row <= emit_last;
        end
    end

    // coordinate store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (accept)
            mem[wr_addr] <= item.coordinate;
        rd_data_reg <= mem[rd_addr_reg];
    end

`include "assert_macros.svh"

    `ASSERT_CLKD(a_wb_only_in_accum, s2_vld_reg |-> state_reg == ST_ACCUM, "accumulate write outside accumulate phase")
    `ASSERT_NEVER(a_emit_row_zero, state_reg == ST_EMIT && cur_row_reg == '0, "emit phase for row zero")
    `ASSERT_CLKD(a_issue_bound, state_reg == ST_ACCUM |-> jp_iss_reg <= cur_row_reg, "issue count past current row")

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import pdm_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD_CYCLES = 300;

    class pair_distance_board;
        logic signed [COORD_BITS-1:0] coord_mem [MAX_STATES_DEF*MAX_DIMS_DEF];
        longint unsigned              row_sums [MAX_STATES_DEF];
        int unsigned                  row_pos;
        int unsigned                  dim_pos;
        logic [METRIC_W-1:0]          metric;
        logic [NSTATES_W-1:0]         num_states;
        logic [NDIMS_W-1:0]           num_dims;
        result_beat_t                 pending_pairs [$];
        int                           fail_count;

        function new();
            foreach (coord_mem[i])
                coord_mem[i] = '0;
            foreach (row_sums[i])
                row_sums[i] = 0;
            row_pos = 0;
            dim_pos = 0;
            metric = METRIC_ABS;
            num_states = NUM_STATES_RST;
            num_dims = NUM_DIMS_RST;
            fail_count = 0;
        endfunction

        function int unsigned dims_in_use();
            if (num_dims == 0)
                return 1;
            if (num_dims > MAX_DIMS_DEF)
                return MAX_DIMS_DEF;
            return num_dims;
        endfunction

        function int unsigned rows_in_use();
            if (num_states == 0)
                return 1;
            if (num_states > MAX_STATES_DEF)
                return MAX_STATES_DEF;
            return num_states;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_METRIC: metric = data[METRIC_W-1:0];
                CFG_STATES: num_states = data[NSTATES_W-1:0];
                CFG_DIMS:   num_dims = data[NDIMS_W-1:0];
                default:    ;
            endcase
        endfunction

        function longint unsigned coord_term(int a, int b);
            int mag;
            mag = (a >= b) ? a - b : b - a;
            if (metric == METRIC_SQR)
                return longint'(mag) * longint'(mag);
            if (metric == METRIC_HAM)
                // integer parts, truncated toward zero
                return ((a / 256) == (b / 256)) ? 0 : 1;
            return mag;
        endfunction

        function void add_coordinate(item_beat_t beat);
            longint unsigned ceiling;
            longint unsigned term;
            int              c;
            int unsigned     nd;
            int unsigned     ns;
            result_beat_t    want;
            ceiling = DIST_MAX;
            nd = dims_in_use();
            ns = rows_in_use();
            if (beat.start_matrix)
            begin
                row_pos = 0;
                dim_pos = 0;
                foreach (row_sums[i])
                    row_sums[i] = 0;
            end
            coord_mem[row_pos*MAX_DIMS_DEF + dim_pos] = beat.coordinate;
            c = int'(beat.coordinate);
            for (int unsigned j = 0; j < row_pos; j++)
            begin
                term = coord_term(c, int'(coord_mem[j*MAX_DIMS_DEF + dim_pos]));
                if (row_sums[j] >= ceiling || term >= ceiling - row_sums[j])
                    row_sums[j] = ceiling;
                else
                    row_sums[j] += term;
            end
            if (dim_pos + 1 >= nd)
            begin
                for (int unsigned j = 0; j < row_pos; j++)
                begin
                    want.row_index = row_pos[IDX_W-1:0];
                    want.col_index = j[IDX_W-1:0];
                    want.distance = row_sums[j][DIST_W-1:0];
                    want.last_of_row = (j + 1 == row_pos);
                    pending_pairs.push_back(want);
                    row_sums[j] = 0;
                end
                dim_pos = 0;
                row_pos = (row_pos + 1 >= ns) ? 0 : row_pos + 1;
            end
            else
                dim_pos++;
        endfunction

        function void compare_pair(result_beat_t got);
            result_beat_t want;
            if (pending_pairs.size() == 0)
            begin
                $error("result beat with nothing pending: row %0d col %0d distance %0d",
                       got.row_index, got.col_index, got.distance);
                fail_count++;
                return;
            end
            want = pending_pairs.pop_front();
            if (got.row_index !== want.row_index)
            begin
                $error("row_index: expected %0d, got %0d", want.row_index, got.row_index);
                fail_count++;
            end
            if (got.col_index !== want.col_index)
            begin
                $error("col_index: expected %0d, got %0d", want.col_index, got.col_index);
                fail_count++;
            end
            if (got.distance !== want.distance)
            begin
                $error("distance: expected %0d, got %0d", want.distance, got.distance);
                fail_count++;
            end
            if (got.last_of_row !== want.last_of_row)
            begin
                $error("last_of_row: expected %0d, got %0d", want.last_of_row, got.last_of_row);
                fail_count++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  item_valid = 1'b0;
    logic                  item_stall;
    item_beat_t            item_beat = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    result_beat_t          result_beat;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    pair_distance_board board;
    int                 items_sent = 0;
    int                 quiet_cycles = 0;

    // corner rows for a 3 x 2 matrix: full-scale swings and hamming truncation
    logic signed [COORD_BITS-1:0] corner_coords [6] = '{
        16'sh7fff, 16'sh8000,
        16'sh8000, -16'sd255,
        16'sd255,  -16'sd256
    };

    pairwise_distance_matrix_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_beat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_beat),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
            board.add_coordinate(item_beat);
        if (rst_n && result_valid && !result_stall)
            board.compare_pair(result_beat);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // result side: random stalls, stall-free stretches, one long hold-off
    initial
    begin
        int hold;
        int taken;
        bit long_hold_done;
        taken = 0;
        long_hold_done = 0;
        forever
        begin
            if (!long_hold_done && taken >= 120)
            begin
                long_hold_done = 1;
                hold = LONG_HOLD_CYCLES;
            end
            else if ((taken % 48) < 12)
                hold = 0;
            else
                hold = $urandom_range(0, 12);
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            result_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(result_valid && !result_stall));
            taken++;
        end
    end

    function automatic logic signed [COORD_BITS-1:0] pick_coordinate();
        case ($urandom_range(0, 7))
            0:       case ($urandom_range(0, 3))
                         0:       return 16'sh7fff;
                         1:       return 16'sh8000;
                         2:       return 16'sh0000;
                         default: return 16'shffff;
                     endcase
            1, 2:    return COORD_BITS'(int'($urandom_range(0, 1200)) - 600);
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    task automatic send_coordinate(input logic signed [COORD_BITS-1:0] coord,
                                   input logic start);
        int gap;
        gap = ((items_sent % 40) < 10) ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item_beat <= '{coordinate: coord, start_matrix: start};
        do
            @(posedge clk);
        while (!(item_valid && !item_stall));
        items_sent++;
    endtask

    // wait out every pending pair, then the pipe depth for beats with no result
    task automatic settle();
        while (board.pending_pairs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_registers(input logic [METRIC_W-1:0] metric,
                                     input logic [CFG_DATA_W-1:0] states,
                                     input logic [CFG_DATA_W-1:0] dims,
                                     output bit dims_grew);
        int unsigned           old_dims;
        logic [CFG_IDX_W-1:0]  idx [3];
        logic [CFG_DATA_W-1:0] val [3];
        old_dims = board.dims_in_use();
        idx = '{CFG_METRIC, CFG_STATES, CFG_DIMS};
        val = '{CFG_DATA_W'(metric), states, dims};
        for (int k = 0; k < 3; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data <= val[k];
            do
                @(posedge clk);
            while (!(cfg_valid && cfg_ready));
            board.set_register(idx[k], val[k]);
        end
        cfg_valid <= 1'b0;
        dims_grew = board.dims_in_use() > old_dims;
    endtask

    task automatic run_corners(input logic [METRIC_W-1:0] metric);
        bit grew;
        program_registers(metric, 6'd3, 6'd2, grew);
        for (int i = 0; i < 6; i++)
            send_coordinate(corner_coords[i], i == 0);
        item_valid <= 1'b0;
        settle();
    endtask

    // a raised dimension count restarts the matrix so no unwritten entry is read
    task automatic run_phase(input logic [METRIC_W-1:0] metric,
                             input logic [CFG_DATA_W-1:0] states,
                             input logic [CFG_DATA_W-1:0] dims,
                             input int count);
        bit grew;
        bit start;
        program_registers(metric, states, dims, grew);
        for (int i = 0; i < count; i++)
        begin
            start = (i == 0 && grew) || ($urandom_range(0, 19) == 0);
            send_coordinate(pick_coordinate(), start);
        end
        item_valid <= 1'b0;
        settle();
    endtask

    initial
    begin
        board = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_corners(METRIC_ABS);
        run_corners(METRIC_SQR);
        run_corners(METRIC_HAM);
        run_corners(METRIC_RSVD);

        run_phase(METRIC_ABS, 6'd32, 6'd1, 40);
        // fewer rows while deep in a matrix: current row wraps once done
        run_phase(METRIC_HAM, 6'd5, 6'd1, 20);
        run_phase(METRIC_SQR, 6'd4, 6'd16, 40);
        run_phase(METRIC_HAM, 6'd0, 6'd0, 12);
        run_phase(METRIC_RSVD, 6'd63, 6'd31, 34);
        run_phase(METRIC_SQR, 6'd5, 6'd3, 30);
        for (int p = 0; p < 4; p++)
            run_phase(METRIC_W'($urandom_range(0, 3)), CFG_DATA_W'($urandom_range(1, 12)),
                      CFG_DATA_W'($urandom_range(1, 6)), 20);

        settle();
        if (board.fail_count == 0 && board.pending_pairs.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/pdm_pkg.sv
rtl/pairwise_distance_matrix_core.sv
tb/tb_top.sv
